// ===== rtl/look_at_view_matrix_core_assert.svh =====
// Assertion macros for the look-at view matrix block.
// They expect i_clk and an active-low i_rst_n in the including scope.
`ifndef LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH

// same-cycle implication
`define LAV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LAV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lav_pkg.sv =====
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and arithmetic helpers of the look-at view matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

    typedef logic [2:0][31:0] t_vec3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_FWD  = 3'd1,
        ST_ZERO_UP   = 3'd2,
        ST_PARALLEL  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    // 32x32 signed product
    function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    // drop frac fraction bits, round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] x,
                                                    input int frac);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? 64'(-x) : 64'(x);
        r = (m + (64'd1 << (frac - 1))) >> frac;
        return x[63] ? $signed(-r) : $signed(r);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lav_norm.sv =====
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: zero test, exact pre-shift, integer square
// root (four digits per stage) and three long dividers (four bits per stage).
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  lav_pkg::t_vec3      i_vec,
    input  logic [30:0]         i_min_sq,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output lav_pkg::t_vec3      o_vec,
    output logic                o_zero,
    output logic [SIDE_W-1:0]   o_side
);
    import lav_pkg::*;

    localparam int QW  = FRAC_BITS + 1;        // quotient bits
    localparam int NW  = 33 + FRAC_BITS;       // dividend bits
    localparam int DS  = (FRAC_BITS + 4) / 4;  // divider stages
    localparam int LAT = 16 + DS;

    logic [LAT-1:0]    r_vld;
    logic [SIDE_W-1:0] r_side [LAT];
    logic [2:0]        r_sgn  [LAT-1];
    logic              r_zero [LAT-2];
    t_vec3             r_smag [11];

    t_vec3        r_mag1, r_mag2, r_mag3;
    logic [63:0]  r_sq2 [3];
    logic [63:0]  r_sq5 [3];
    logic [4:0]   r_shift;

    logic [63:0]  r_sr_n    [9];
    logic [35:0]  r_sr_rem  [9];
    logic [31:0]  r_sr_root [9];

    t_vec3                   r_dr   [DS+1];
    logic [2:0][QW-1:0]      r_dq   [DS+1];
    logic [2:0][NW-1:0]      r_num  [DS+1];
    logic [31:0]             r_len  [DS+1];

    t_vec3        r_out;

    logic [63:0]  n_sum1, n_sum2;
    logic [31:0]  n_max;
    logic [4:0]   n_pos;
    logic [4:0]   n_shift;

    // control chains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int k = 1; k < LAT; k++) r_side[k] <= r_side[k-1];
    end

    // magnitudes, squares, zero test and pre-shift
    always_comb begin
        n_sum1 = r_sq2[0] + r_sq2[1] + r_sq2[2];
        n_max  = r_mag2[0];
        if (r_mag2[1] > n_max) n_max = r_mag2[1];
        if (r_mag2[2] > n_max) n_max = r_mag2[2];
        n_pos = '0;
        for (int b = 0; b < 32; b++) begin
            if (n_max[b]) n_pos = 5'(b);
        end
        n_shift = (n_pos >= 5'd30 || n_max == '0) ? 5'd0 : 5'd30 - n_pos;
        n_sum2 = r_sq5[0] + r_sq5[1] + r_sq5[2];
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_mag1[l]   <= i_vec[l][31] ? 32'(-i_vec[l]) : i_vec[l];
            r_sgn[0][l] <= i_vec[l][31];
            r_sq2[l]    <= r_mag1[l] * r_mag1[l];
            r_sq5[l]    <= r_smag[0][l] * r_smag[0][l];
            r_smag[0][l] <= r_mag3[l] << r_shift;
        end
        for (int k = 1; k < LAT - 1; k++) r_sgn[k] <= r_sgn[k-1];
        for (int k = 1; k < LAT - 2; k++) r_zero[k] <= r_zero[k-1];
        for (int k = 1; k < 11; k++) r_smag[k] <= r_smag[k-1];
        r_mag2    <= r_mag1;
        r_mag3    <= r_mag2;
        r_shift   <= n_shift;
        r_zero[0] <= (n_sum1 <= 64'({i_min_sq, {FRAC_BITS{1'b0}}}));
        r_sr_n[0]    <= n_sum2;
        r_sr_rem[0]  <= '0;
        r_sr_root[0] <= '0;
    end

    // square root, four result bits per stage
    for (genvar g = 0; g < 8; g++) begin : g_sqrt
        logic [35:0] c_rem;
        logic [31:0] c_root;
        always_comb begin
            logic [35:0] trial;
            c_rem  = r_sr_rem[g];
            c_root = r_sr_root[g];
            for (int k = 0; k < 4; k++) begin
                c_rem = {c_rem[33:0], r_sr_n[g][62 - 8*g - 2*k +: 2]};
                trial = {2'b00, c_root, 2'b01};
                if (c_rem >= trial) begin
                    c_rem  = c_rem - trial;
                    c_root = {c_root[30:0], 1'b1};
                end else begin
                    c_root = {c_root[30:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_sr_n[g+1]    <= r_sr_n[g];
            r_sr_rem[g+1]  <= c_rem;
            r_sr_root[g+1] <= c_root;
        end
    end

    // divider setup: quotient = (mag << F + len/2) / len
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_num[0][l] <= (NW'(r_smag[10][l]) << FRAC_BITS) + NW'(r_sr_root[8] >> 1);
            r_dr[0][l]  <= 32'(((NW'(r_smag[10][l]) << FRAC_BITS)
                               + NW'(r_sr_root[8] >> 1)) >> QW);
        end
        r_dq[0]  <= '0;
        r_len[0] <= r_sr_root[8];
    end

    for (genvar g = 0; g < DS; g++) begin : g_div
        t_vec3              c_dr;
        logic [2:0][QW-1:0] c_dq;
        always_comb begin
            logic [32:0] trial;
            int          idx;
            c_dr = r_dr[g];
            c_dq = r_dq[g];
            for (int l = 0; l < 3; l++) begin
                for (int k = 0; k < 4; k++) begin
                    idx = FRAC_BITS - (4*g + k);
                    if (idx >= 0) begin
                        trial = {c_dr[l], r_num[g][l][idx]};
                        if (trial >= {1'b0, r_len[g]}) begin
                            c_dr[l] = 32'(trial - {1'b0, r_len[g]});
                            c_dq[l] = {c_dq[l][QW-2:0], 1'b1};
                        end else begin
                            c_dr[l] = trial[31:0];
                            c_dq[l] = {c_dq[l][QW-2:0], 1'b0};
                        end
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_dr[g+1]  <= c_dr;
            r_dq[g+1]  <= c_dq;
            r_num[g+1] <= r_num[g];
            r_len[g+1] <= r_len[g];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_out[l] <= r_sgn[LAT-2][l] ? 32'(-32'(r_dq[DS][l])) : 32'(r_dq[DS][l]);
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_vec   = r_out;
    assign o_zero  = r_zero[LAT-3];
    assign o_side  = r_side[LAT-1];

endmodule

`default_nettype wire

// ===== rtl/lav_cross.sv =====
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage cross product: six products, then differences rounded to QF.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_cross #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  lav_pkg::t_vec3      i_p,
    input  lav_pkg::t_vec3      i_q,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output lav_pkg::t_vec3      o_vec,
    output logic [SIDE_W-1:0]   o_side
);
    import lav_pkg::*;

    logic               r_v1, r_v2;
    logic signed [63:0] r_pa [3];
    logic signed [63:0] r_pb [3];
    logic [SIDE_W-1:0]  r_s1, r_s2;
    t_vec3              r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa[0] <= smul(i_p[1], i_q[2]);
        r_pb[0] <= smul(i_p[2], i_q[1]);
        r_pa[1] <= smul(i_p[2], i_q[0]);
        r_pb[1] <= smul(i_p[0], i_q[2]);
        r_pa[2] <= smul(i_p[0], i_q[1]);
        r_pb[2] <= smul(i_p[1], i_q[0]);
        r_s1    <= i_side;
        for (int l = 0; l < 3; l++) begin
            r_out[l] <= 32'(rnd_frac(r_pa[l] - r_pb[l], FRAC_BITS));
        end
        r_s2 <= r_s1;
    end

    assign o_valid = r_v2;
    assign o_vec   = r_out;
    assign o_side  = r_s2;

endmodule

`default_nettype wire

// ===== rtl/look_at_view_matrix_core.sv =====
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Right-handed look-at view matrix in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with eye, aim and upward on the i_ ports; the item transfers
//   on an edge where start is high and busy is low. busy then stays high
//   until an internal counter runs out, and no new item is taken meanwhile.
//   Each good item gives four results, columns 0..3 in order on consecutive
//   cycles, each marked by o_strobe for one cycle; o_last_column flags
//   column 3. An error gives one result with zero elements, column 0,
//   o_last_column high and the error code in o_status.
//   The path to the first result runs through two normalizers in series
//   (forward, with up alongside, then side): each runs a square root at four
//   bits per stage and the dividers at four quotient bits per stage. Items
//   overlap freely inside the pipeline.
//   The receiver cannot stall; results must be taken as they appear.
//   min_squared_length sits at byte address 0 of the APB port; write it
//   only while no item is in flight. Synchronous reset empties the pipeline
//   and clears the register to 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "look_at_view_matrix_core_assert.svh"

module look_at_view_matrix_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_eye_x,
    input  logic signed [31:0]   i_eye_y,
    input  logic signed [31:0]   i_eye_z,
    input  logic signed [31:0]   i_aim_x,
    input  logic signed [31:0]   i_aim_y,
    input  logic signed [31:0]   i_aim_z,
    input  logic signed [31:0]   i_upward_x,
    input  logic signed [31:0]   i_upward_y,
    input  logic signed [31:0]   i_upward_z,
    output logic                 o_strobe,
    output logic signed [31:0]   o_elem_row0,
    output logic signed [31:0]   o_elem_row1,
    output logic signed [31:0]   o_elem_row2,
    output logic signed [31:0]   o_elem_row3,
    output logic [1:0]           o_column_index,
    output logic                 o_last_column,
    output logic [2:0]           o_status,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import lav_pkg::*;

    localparam logic [1:0] ADDR_MIN_SQ = 2'd0;

    typedef struct packed {
        t_vec3 eye;
        logic  ovf;
    } t_side_a;

    typedef struct packed {
        t_vec3 fwd;
        t_vec3 eye;
        logic  ovf;
        logic  zf;
        logic  zu;
    } t_side_c;

    typedef struct packed {
        t_vec3 sd;
        t_vec3 fwd;
        t_vec3 eye;
        logic  ovf;
        logic  zf;
        logic  zu;
        logic  zc;
    } t_side_d;

    // config register
    logic [30:0] r_min_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sq <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_min_sq <= pwdata[30:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_SQ) ? {1'b0, r_min_sq} : '0;

    // input side
    logic        w_accept;
    logic [1:0]  r_busy_cnt;
    logic        r_v0, r_v1;
    t_vec3       r_eye0, r_aim0, r_up0;
    t_vec3       r_eye1, r_up1, r_d1;
    logic        r_ovf1;
    logic [32:0] n_diff [3];
    logic        n_ovf;

    assign w_accept = start && !busy;
    assign busy     = (r_busy_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_cnt <= '0;
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy_cnt <= 2'd3;
            end else if (r_busy_cnt != 2'd0) begin
                r_busy_cnt <= r_busy_cnt - 2'd1;
            end
            r_v0 <= w_accept;
            r_v1 <= r_v0;
        end
    end

    always_comb begin
        n_ovf = 1'b0;
        for (int l = 0; l < 3; l++) begin
            n_diff[l] = 33'($signed(r_aim0[l])) - 33'($signed(r_eye0[l]));
            if (n_diff[l][32] != n_diff[l][31]) n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_eye0 <= {i_eye_z, i_eye_y, i_eye_x};
            r_aim0 <= {i_aim_z, i_aim_y, i_aim_x};
            r_up0  <= {i_upward_z, i_upward_y, i_upward_x};
        end
        for (int l = 0; l < 3; l++) r_d1[l] <= n_diff[l][31:0];
        r_eye1 <= r_eye0;
        r_up1  <= r_up0;
        r_ovf1 <= n_ovf;
    end

    // forward and up normalization
    logic    na_valid, nb_valid, na_zero, nb_zero;
    t_vec3   na_vec, nb_vec;
    t_side_a na_side;

    lav_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_side_a))) u_norm_fwd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .i_vec    (r_d1),
        .i_min_sq (r_min_sq),
        .i_side   (t_side_a'{eye: r_eye1, ovf: r_ovf1}),
        .o_valid  (na_valid),
        .o_vec    (na_vec),
        .o_zero   (na_zero),
        .o_side   (na_side)
    );

    lav_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_norm_up (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .i_vec    (r_up1),
        .i_min_sq (r_min_sq),
        .i_side   (1'b0),
        .o_valid  (nb_valid),
        .o_vec    (nb_vec),
        .o_zero   (nb_zero),
        .o_side   ()
    );

    // side = forward x up
    logic    c1_valid;
    t_vec3   c1_vec;
    t_side_c c1_side;

    lav_cross #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_side_c))) u_cross_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (na_valid && nb_valid),
        .i_p     (na_vec),
        .i_q     (nb_vec),
        .i_side  (t_side_c'{fwd: na_vec, eye: na_side.eye, ovf: na_side.ovf,
                            zf: na_zero, zu: nb_zero}),
        .o_valid (c1_valid),
        .o_vec   (c1_vec),
        .o_side  (c1_side)
    );

    logic    nc_valid, nc_zero;
    t_vec3   nc_vec;
    t_side_c nc_side;

    lav_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_side_c))) u_norm_side (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c1_valid),
        .i_vec    (c1_vec),
        .i_min_sq (r_min_sq),
        .i_side   (c1_side),
        .o_valid  (nc_valid),
        .o_vec    (nc_vec),
        .o_zero   (nc_zero),
        .o_side   (nc_side)
    );

    // camera up = side x forward
    logic    c2_valid;
    t_vec3   c2_vec;
    t_side_d c2_side;

    lav_cross #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_side_d))) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nc_valid),
        .i_p     (nc_vec),
        .i_q     (nc_side.fwd),
        .i_side  (t_side_d'{sd: nc_vec, fwd: nc_side.fwd, eye: nc_side.eye,
                            ovf: nc_side.ovf, zf: nc_side.zf, zu: nc_side.zu,
                            zc: nc_zero}),
        .o_valid (c2_valid),
        .o_vec   (c2_vec),
        .o_side  (c2_side)
    );

    // translation: dot products with eye
    logic               r_v3, r_v4;
    logic signed [63:0] r_ps [3];
    logic signed [63:0] r_pu [3];
    logic signed [63:0] r_pf [3];
    t_vec3              r_sd3, r_cu3, r_f3, r_sd4, r_cu4, r_f4, r_t4;
    logic [3:0]         r_flg3;
    t_status            r_stat4;
    logic signed [63:0] n_t [3];
    logic               n_tov;
    t_status            n_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= c2_valid;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        n_t[0] = -rnd_frac(r_ps[0] + r_ps[1] + r_ps[2], FRAC_BITS);
        n_t[1] = -rnd_frac(r_pu[0] + r_pu[1] + r_pu[2], FRAC_BITS);
        n_t[2] =  rnd_frac(r_pf[0] + r_pf[1] + r_pf[2], FRAC_BITS);
        n_tov  = 1'b0;
        for (int l = 0; l < 3; l++) begin
            if (n_t[l][63:31] != {33{n_t[l][31]}}) n_tov = 1'b1;
        end
        // check order: diff overflow, zero fwd, zero up, parallel, translation
        if (r_flg3[3])      n_stat = ST_OVERFLOW;
        else if (r_flg3[2]) n_stat = ST_ZERO_FWD;
        else if (r_flg3[1]) n_stat = ST_ZERO_UP;
        else if (r_flg3[0]) n_stat = ST_PARALLEL;
        else if (n_tov)     n_stat = ST_OVERFLOW;
        else                n_stat = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_ps[l] <= smul(c2_side.sd[l], c2_side.eye[l]);
            r_pu[l] <= smul(c2_vec[l], c2_side.eye[l]);
            r_pf[l] <= smul(c2_side.fwd[l], c2_side.eye[l]);
            r_t4[l] <= n_t[l][31:0];
        end
        r_sd3   <= c2_side.sd;
        r_cu3   <= c2_vec;
        r_f3    <= c2_side.fwd;
        r_flg3  <= {c2_side.ovf, c2_side.zf, c2_side.zu, c2_side.zc};
        r_sd4   <= r_sd3;
        r_cu4   <= r_cu3;
        r_f4    <= r_f3;
        r_stat4 <= n_stat;
    end

    // column serializer; busy spaces the items so that each arrives after the last one's columns are out
    logic        r_run;
    logic [1:0]  r_beat;
    logic [1:0]  n_col;
    logic [31:0] n_row [4];

    assign n_col = r_v4 ? 2'd0 : r_beat;

    always_comb begin
        if (n_col == 2'd3) begin
            n_row[0] = r_t4[0];
            n_row[1] = r_t4[1];
            n_row[2] = r_t4[2];
            n_row[3] = 32'd1 << FRAC_BITS;
        end else begin
            n_row[0] = r_sd4[n_col];
            n_row[1] = r_cu4[n_col];
            n_row[2] = 32'(-r_f4[n_col]);
            n_row[3] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
            r_run    <= 1'b0;
            r_beat   <= '0;
        end else if (r_v4) begin
            o_strobe <= 1'b1;
            r_run    <= (r_stat4 == ST_OK);
            r_beat   <= 2'd1;
        end else if (r_run) begin
            o_strobe <= 1'b1;
            r_beat   <= r_beat + 2'd1;
            if (r_beat == 2'd3) r_run <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && r_stat4 != ST_OK) begin
            o_elem_row0    <= '0;
            o_elem_row1    <= '0;
            o_elem_row2    <= '0;
            o_elem_row3    <= '0;
            o_column_index <= '0;
            o_last_column  <= 1'b1;
            o_status       <= r_stat4;
        end else begin
            o_elem_row0    <= n_row[0];
            o_elem_row1    <= n_row[1];
            o_elem_row2    <= n_row[2];
            o_elem_row3    <= n_row[3];
            o_column_index <= n_col;
            o_last_column  <= (n_col == 2'd3);
            o_status       <= ST_OK;
        end
    end

    `LAV_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "no busy after transfer")
    `LAV_ASSERT_NOW(a_error_single, o_strobe && o_status != ST_OK,
                    o_last_column && o_column_index == 2'd0, "error result malformed")
    `LAV_ASSERT_NEXT(a_columns_in_order, o_strobe && !o_last_column,
                     o_strobe && o_column_index == $past(o_column_index) + 2'd1,
                     "column sequence broken")
    `LAV_ASSERT_NOW(a_norm_lockstep, na_valid || nb_valid, na_valid && nb_valid,
                    "normalizers out of step")

endmodule

`default_nettype wire
